// ----- sv/ajm_pkg.sv -----
// ----------------------------------------------------------------------------
// ajm_pkg: shared constants and types for the accel magnitude and jerk unit
// sample widths, derived datapath widths, sequencer states and unit status
// ----------------------------------------------------------------------------
package ajm_pkg;

	// width of one axis sample, two's complement
	localparam int SAMPLE_BITS = 16;
	// one g in counts at +/-2 g full scale
	localparam int ONE_G_SHIFT = SAMPLE_BITS - 2;

	// absolute axis value or absolute axis difference
	localparam int OPND_W = SAMPLE_BITS + 1;
	// square of an operand and the sum of three of them
	localparam int SUM_W  = 2 * OPND_W;
	// root of a SUM_W radicand
	localparam int ROOT_W = SUM_W / 2;
	localparam int JERK_W = SAMPLE_BITS + 1;

	// three magnitude terms then three jerk terms
	localparam int NUM_AXES  = 3;
	localparam int NUM_TERMS = 2 * NUM_AXES;
	localparam int IDX_W     = $clog2(NUM_TERMS);
	localparam int CNT_W     = $clog2(ROOT_W);

	// stream payload widths, whole bytes
	localparam int IN_W      = NUM_AXES * SAMPLE_BITS;
	localparam int IN_TD_W   = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W     = 4 * SAMPLE_BITS + JERK_W;
	localparam int OUT_TD_W  = ((OUT_W + 7) / 8) * 8;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [OPND_W-1:0]             opnd_t;
	typedef logic [SUM_W-1:0]              sum_t;
	typedef logic [ROOT_W-1:0]             root_t;

	localparam sample_t ONE_G = sample_t'(64'd1 << ONE_G_SHIFT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT_MAG,
		ST_ROOT_JERK,
		ST_OUT
	} ajm_state_t;

	// status of the square and accumulate unit
	typedef struct packed {
		logic done;
		sum_t sum_mag;
		sum_t sum_jerk;
	} sq_res_t;

	// status of the square root unit
	typedef struct packed {
		logic  done;
		root_t root;
	} rt_res_t;

endpackage

// ----- sv/ajm_sq_acc.sv -----
// ----------------------------------------------------------------------------
// ajm_sq_acc: shared squarer with two accumulators
// one multiplier squares the three axes then the three axis differences,
// one term per cycle, into the magnitude and jerk sums
// ----------------------------------------------------------------------------
module ajm_sq_acc import ajm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  sample_t cur_x,
	input  sample_t cur_y,
	input  sample_t cur_z,
	input  sample_t prev_x,
	input  sample_t prev_y,
	input  sample_t prev_z,
	output sq_res_t res
);

	logic             run_q;
	logic [IDX_W-1:0] idx_q;
	logic             v_s1, j_s1, last_s1;
	logic             v_s2, j_s2, last_s2;
	opnd_t            op_s1;
	sum_t             prod_s2;
	sum_t             acc_mag_q, acc_jerk_q;
	logic             done_q;

	logic signed [OPND_W-1:0] a_sel, b_sel, diff;
	opnd_t                    op_abs;

	// operand select: axis minus zero, or axis minus kept sample
	always_comb begin
		a_sel = OPND_W'(cur_x);
		b_sel = '0;
		unique case (idx_q)
			IDX_W'(0): a_sel = OPND_W'(cur_x);
			IDX_W'(1): a_sel = OPND_W'(cur_y);
			IDX_W'(2): a_sel = OPND_W'(cur_z);
			IDX_W'(3): begin
				a_sel = OPND_W'(cur_x);
				b_sel = OPND_W'(prev_x);
			end
			IDX_W'(4): begin
				a_sel = OPND_W'(cur_y);
				b_sel = OPND_W'(prev_y);
			end
			IDX_W'(5): begin
				a_sel = OPND_W'(cur_z);
				b_sel = OPND_W'(prev_z);
			end
			default: begin
				a_sel = '0;
				b_sel = '0;
			end
		endcase
		diff   = a_sel - b_sel;
		op_abs = diff[OPND_W-1] ? opnd_t'(-diff) : opnd_t'(diff);
	end

	// issue counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			idx_q <= '0;
		end else if (run_q) begin
			if (idx_q == IDX_W'(NUM_TERMS - 1)) begin
				run_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// operand, product, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= run_q;
			v_s2   <= v_s1;
			done_q <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op_abs;
		j_s1    <= idx_q >= IDX_W'(NUM_AXES);
		last_s1 <= idx_q == IDX_W'(NUM_TERMS - 1);
		prod_s2 <= op_s1 * op_s1;
		j_s2    <= j_s1;
		last_s2 <= last_s1;
		if (start) begin
			acc_mag_q  <= '0;
			acc_jerk_q <= '0;
		end else if (v_s2) begin
			if (j_s2) begin
				acc_jerk_q <= acc_jerk_q + prod_s2;
			end else begin
				acc_mag_q <= acc_mag_q + prod_s2;
			end
		end
	end

	assign res.done     = done_q;
	assign res.sum_mag  = acc_mag_q;
	assign res.sum_jerk = acc_jerk_q;

endmodule

// ----- sv/ajm_isqrt.sv -----
// ----------------------------------------------------------------------------
// ajm_isqrt: iterative integer square root
// one root bit per cycle, floor result, done pulses once the root is final
// ----------------------------------------------------------------------------
module ajm_isqrt import ajm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  sum_t    radicand,
	output rt_res_t res
);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	sum_t             rad_q;
	logic [ROOT_W+1:0] rem_q;
	root_t            root_q;

	logic [ROOT_W+1:0] rem_sh, trial;
	logic              take;

	// one compare and subtract step
	always_comb begin
		rem_sh = {rem_q[ROOT_W-1:0], rad_q[SUM_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		take   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign res.done = done_q;
	assign res.root = root_q;

endmodule

// ----- sv/accel_magnitude_and_jerk_unit.sv -----
// ----------------------------------------------------------------------------
// accel_magnitude_and_jerk_unit: accelerometer magnitude and jerk
// per sample: axes, floor sqrt of sum of squares, floor sqrt of squared
// differences from the kept previous sample, idle and fault results
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  cfg      | cfg_wr_en          | cfg_wr_data: sensor_present
//  s (in)   | s_tvalid/s_tready  | s_tuser: read_ok; s_tdata: raw_x, y, z
//  m (out)  | m_tvalid/m_tready  | m_tuser: sample_valid; m_tdata: axes, mag, jerk
//
//  - a valid sample goes from acceptance to m_tvalid through the shared
//    squarer (6 terms, 2 pipeline stages, done flag), then two passes
//    through the one bit-per-cycle root unit (start plus 17 root bits)
//  - sensor absent or read failure: result shows in the cycle after acceptance
//  - one item in flight; s_tready is low from acceptance until m_tvalid
//    is taken, and the result holds while m_tready is low
//  - asynchronous reset clears the sequencer, sensor_present and the kept
//    sample (x = y = 0, z = one g)
//
module accel_magnitude_and_jerk_unit import ajm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// sensor_present register
	input  logic                cfg_wr_en,
	input  logic [0:0]          cfg_wr_data,     // [0] sensor_present
	// input items
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_TD_W-1:0]  s_tdata,         // raw_x, raw_y, raw_z
	input  logic [0:0]          s_tuser,         // [0] read_ok
	// result items
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_TD_W-1:0] m_tdata,         // accel_x, y, z, magnitude, jerk
	output logic [0:0]          m_tuser          // [0] sample_valid
);

	ajm_state_t state_q, state_d;
	logic       present_q;

	// captured sample and kept previous sample
	sample_t x_q, y_q, z_q;
	sample_t last_x_q, last_y_q, last_z_q;

	// result register
	logic                    ov_q;
	sample_t                 ox_q, oy_q, oz_q;
	logic [SAMPLE_BITS-1:0]  omag_q;
	logic [JERK_W-1:0]       ojerk_q;

	// sequencer controls
	logic    sq_start, rt_start;
	sum_t    rt_radicand;
	logic    ld_in, ld_idle, ld_fail, ld_mag, ld_done;
	sq_res_t sq;
	rt_res_t rt;

	ajm_sq_acc u_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.cur_x  (x_q),
		.cur_y  (y_q),
		.cur_z  (z_q),
		.prev_x (last_x_q),
		.prev_y (last_y_q),
		.prev_z (last_z_q),
		.res    (sq)
	);

	// one root unit, used for magnitude then for jerk
	ajm_isqrt u_rt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rt_start),
		.radicand (rt_radicand),
		.res      (rt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer strobes
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		sq_start    = 1'b0;
		rt_start    = 1'b0;
		rt_radicand = sq.sum_mag;
		ld_in       = 1'b0;
		ld_idle     = 1'b0;
		ld_fail     = 1'b0;
		ld_mag      = 1'b0;
		ld_done     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					priority if (!present_q) begin
						// no sensor: idle result, kept sample untouched
						ld_idle = 1'b1;
						state_d = ST_OUT;
					end else if (!s_tuser[0]) begin
						// bus failure: all zero result
						ld_fail = 1'b1;
						state_d = ST_OUT;
					end else begin
						ld_in    = 1'b1;
						sq_start = 1'b1;
						state_d  = ST_SQUARE;
					end
				end
			end
			ST_SQUARE: begin
				if (sq.done) begin
					rt_start = 1'b1;
					state_d  = ST_ROOT_MAG;
				end
			end
			ST_ROOT_MAG: begin
				if (rt.done) begin
					// magnitude is final; reuse the root unit for jerk
					ld_mag      = 1'b1;
					rt_start    = 1'b1;
					rt_radicand = sq.sum_jerk;
					state_d     = ST_ROOT_JERK;
				end
			end
			ST_ROOT_JERK: begin
				if (rt.done) begin
					ld_done = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration and kept sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			last_z_q  <= ONE_G;
		end else begin
			if (cfg_wr_en) begin
				present_q <= cfg_wr_data[0];
			end
			// only a valid sample replaces the kept one
			if (ld_done) begin
				last_x_q <= x_q;
				last_y_q <= y_q;
				last_z_q <= z_q;
			end
		end
	end

	// sample capture and result register
	always_ff @(posedge clk) begin
		if (ld_in) begin
			x_q <= s_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
			y_q <= s_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
			z_q <= s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
		end
		if (ld_idle) begin
			ov_q    <= 1'b0;
			ox_q    <= '0;
			oy_q    <= '0;
			oz_q    <= ONE_G;
			omag_q  <= ONE_G;
			ojerk_q <= '0;
		end else if (ld_fail) begin
			ov_q    <= 1'b0;
			ox_q    <= '0;
			oy_q    <= '0;
			oz_q    <= '0;
			omag_q  <= '0;
			ojerk_q <= '0;
		end else if (ld_mag) begin
			omag_q <= rt.root[SAMPLE_BITS-1:0];
		end else if (ld_done) begin
			ov_q    <= 1'b1;
			ox_q    <= x_q;
			oy_q    <= y_q;
			oz_q    <= z_q;
			ojerk_q <= rt.root[JERK_W-1:0];
		end
	end

	// pack fields lowest first, zero filled to whole bytes
	assign m_tdata = {{(OUT_TD_W - OUT_W){1'b0}}, ojerk_q, omag_q, oz_q, oy_q, ox_q};
	assign m_tuser = ov_q;

endmodule
